// File: rtl/hims_pkg.sv
`default_nettype none
package hims_pkg;
   localparam int MaxElements = 64;
   localparam int ValueWidth = 32;
   localparam int CountWidth = 11;
   localparam int ThreshWidth = 7;
   localparam logic [ThreshWidth-1:0] ThreshReset = 7'd5;
   localparam logic [CountWidth-1:0] CountMax = 11'd2047;
endpackage
`default_nettype wire

// File: rtl/hybrid_insertion_merge_sort_core.sv
`default_nettype none
// Hybrid merge/insertion sorter.
// req_: one signed value per transfer, tdata = value, tlast = last element.
// On the last element the core drops req_tready and sorts the run with
// top-down merge sort, segments no longer than the leaf threshold being
// insertion sorted. Both stores share one read address and have one read
// port each; these set the pace of each merge step, of the copy into
// scratch ahead of each merge, of each insertion key and shift, and of
// the stack work per segment.
// rsp_: one transfer per sorted element in ascending order; tlast on the
// final one. tuser = {overflow, comparison_count}; the count is nonzero only
// on the last element. Each element is read from the data store, then offered.
// Elements beyond capacity are dropped and flagged.
// A stalled rsp_tready holds the current element; the core waits.
// csr_: writes the 7-bit leaf threshold (reset 5); write only while idle.
// Reset is synchronous; the run state clears, the stores are not cleared.
module hybrid_insertion_merge_sort_core #(
   parameter int MAX_ELEMENTS = hims_pkg::MaxElements,
   parameter int VALUE_WIDTH  = hims_pkg::ValueWidth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    req_tdata,  // value
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [((VALUE_WIDTH+7)/8)*8-1:0]    rsp_tdata,  // sorted_value
   output logic                                     rsp_tlast,
   output logic      [hims_pkg::CountWidth:0]       rsp_tuser,  // count, overflow
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hims_pkg::ThreshWidth-1:0]    csr_data
);
   import hims_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int NW = AW + 1;
   localparam int DW = ((VALUE_WIDTH+7)/8)*8;
   localparam int SD = 2*AW + 1;
   localparam int SPW = $clog2(SD+1);

   typedef enum logic [4:0] {
      S_LOAD, S_POP, S_PUSHL, S_INS_I, S_INS_K, S_INS_KW, S_INS_J, S_INS_JW,
      S_CP, S_CPW, S_MRG, S_MRA, S_MRB, S_MRW, S_OUT_RD, S_OUT_W, S_OUT
   } state_type;

   typedef struct packed {
      logic [NW-1:0] lo;
      logic [NW-1:0] len;
      logic          merge;
   } frame_type;

   state_type state_ff;
   logic [ThreshWidth-1:0] thr_ff;
   logic [NW-1:0] cnt_ff, lo_ff, len_ff, half_ff, i_ff, j_ff, a_ff, b_ff, k_ff;
   logic [CountWidth-1:0] cmp_ff;
   logic ovf_ff;
   logic [VALUE_WIDTH-1:0] key_ff, ha_ff;
   frame_type stk_ff [SD];
   logic [SPW-1:0] sp_ff;

   logic d_we, s_we;
   logic [AW-1:0] d_wa, d_ra, s_ra;
   logic [VALUE_WIDTH-1:0] d_wd, d_rd, s_rd;

   hims_ram #(.Width(VALUE_WIDTH), .Depth(MAX_ELEMENTS)) u_data (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));
   hims_ram #(.Width(VALUE_WIDTH), .Depth(MAX_ELEMENTS)) u_scratch (
      .clock, .wr_en(s_we), .wr_addr(d_wa), .wr_data(d_rd),
      .rd_addr(s_ra), .rd_data(s_rd));

   function automatic logic lt(input logic [VALUE_WIDTH-1:0] x,
                               input logic [VALUE_WIDTH-1:0] y);
      return $signed(x) < $signed(y);
   endfunction

   logic [AW-1:0] rd_a_ff, wr_a_ff;
   logic we_ff, swe_ff;
   logic [VALUE_WIDTH-1:0] wd_ff;
   assign d_ra = rd_a_ff;
   assign s_ra = rd_a_ff;
   assign d_wa = wr_a_ff;
   assign d_we = we_ff;
   assign s_we = swe_ff;
   assign d_wd = wd_ff;

   assign req_tready = (state_ff == S_LOAD);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = DW'($signed(ha_ff));
   assign rsp_tlast  = (k_ff + NW'(1) == cnt_ff);
   assign rsp_tuser  = {ovf_ff, rsp_tlast ? cmp_ff : '0};

   logic is_leaf;
   assign is_leaf = (len_ff <= NW'(1)) || ({1'b0, len_ff} <= (NW+1)'(thr_ff));
   logic [CountWidth-1:0] cmp_inc;
   assign cmp_inc = (cmp_ff == CountMax) ? cmp_ff : cmp_ff + 1'b1;

   always_ff @(posedge clock) begin
      we_ff <= 1'b0;
      swe_ff <= 1'b0;
      if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
      case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               if (cnt_ff < NW'(MAX_ELEMENTS)) begin
                  we_ff <= 1'b1;
                  wr_a_ff <= AW'(cnt_ff);
                  wd_ff <= req_tdata[VALUE_WIDTH-1:0];
                  cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
               if (req_tlast) begin
                  cmp_ff <= '0;
                  stk_ff[0] <= '{lo: '0, len: (cnt_ff < NW'(MAX_ELEMENTS)) ?
                                  cnt_ff + 1'b1 : cnt_ff, merge: 1'b0};
                  sp_ff <= SPW'(1);
                  state_ff <= S_POP;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               k_ff <= '0;
               state_ff <= (cnt_ff == '0) ? S_LOAD : S_OUT_RD;
               rd_a_ff <= '0;
               if (cnt_ff == '0) begin
                  ovf_ff <= 1'b0;
               end
            end else begin
               lo_ff <= stk_ff[sp_ff-1].lo;
               len_ff <= stk_ff[sp_ff-1].len;
               half_ff <= stk_ff[sp_ff-1].len >> 1;
               sp_ff <= sp_ff - SPW'(1);
               if (stk_ff[sp_ff-1].merge) begin
                  k_ff <= '0;
                  state_ff <= S_CP;
               end else begin
                  i_ff <= NW'(1);
                  state_ff <= S_PUSHL;
               end
            end
         end
         S_PUSHL: begin
            if (is_leaf) begin
               state_ff <= S_INS_I;
            end else begin
               stk_ff[sp_ff] <= '{lo: lo_ff, len: len_ff, merge: 1'b1};
               stk_ff[sp_ff+1] <= '{lo: lo_ff + half_ff, len: len_ff - half_ff,
                                    merge: 1'b0};
               stk_ff[sp_ff+2] <= '{lo: lo_ff, len: half_ff, merge: 1'b0};
               sp_ff <= sp_ff + SPW'(3);
               state_ff <= S_POP;
            end
         end
         S_INS_I: begin
            if (i_ff >= len_ff) begin
               state_ff <= S_POP;
            end else begin
               rd_a_ff <= AW'(lo_ff + i_ff);
               j_ff <= i_ff;
               state_ff <= S_INS_K;
            end
         end
         S_INS_K: state_ff <= S_INS_KW;
         S_INS_KW: begin
            key_ff <= d_rd;
            rd_a_ff <= AW'(lo_ff + j_ff - 1'b1);
            state_ff <= S_INS_J;
         end
         S_INS_J: state_ff <= S_INS_JW;
         S_INS_JW: begin
            we_ff <= 1'b1;
            wr_a_ff <= AW'(lo_ff + j_ff);
            if (j_ff == '0) begin
               wd_ff <= key_ff;
               i_ff <= i_ff + 1'b1;
               state_ff <= S_INS_I;
            end else if (lt(key_ff, d_rd)) begin
               cmp_ff <= cmp_inc;
               wd_ff <= d_rd;
               j_ff <= j_ff - 1'b1;
               rd_a_ff <= AW'(lo_ff + j_ff - 2'd2);
               state_ff <= S_INS_J;
            end else begin
               wd_ff <= key_ff;
               i_ff <= i_ff + 1'b1;
               state_ff <= S_INS_I;
            end
         end
         S_CP: begin
            if (k_ff == len_ff) begin
               a_ff <= lo_ff;
               b_ff <= lo_ff + half_ff;
               k_ff <= lo_ff;
               state_ff <= S_MRG;
            end else begin
               rd_a_ff <= AW'(lo_ff + k_ff);
               state_ff <= S_CPW;
            end
         end
         S_CPW: begin
            swe_ff <= 1'b1;
            wr_a_ff <= rd_a_ff;
            k_ff <= k_ff + 1'b1;
            state_ff <= S_CP;
         end
         S_MRG: begin
            if (k_ff == lo_ff + len_ff) begin
               state_ff <= S_POP;
            end else begin
               rd_a_ff <= AW'(a_ff);
               state_ff <= S_MRA;
            end
         end
         S_MRA: begin
            rd_a_ff <= AW'(b_ff);
            state_ff <= S_MRB;
         end
         S_MRB: begin
            ha_ff <= s_rd;
            state_ff <= S_MRW;
         end
         S_MRW: begin
            we_ff <= 1'b1;
            wr_a_ff <= AW'(k_ff);
            k_ff <= k_ff + 1'b1;
            state_ff <= S_MRG;
            if (b_ff == lo_ff + len_ff) begin
               wd_ff <= ha_ff;
               a_ff <= a_ff + 1'b1;
            end else if (a_ff == lo_ff + half_ff) begin
               wd_ff <= s_rd;
               b_ff <= b_ff + 1'b1;
            end else begin
               cmp_ff <= cmp_inc;
               if (lt(ha_ff, s_rd)) begin
                  wd_ff <= ha_ff;
                  a_ff <= a_ff + 1'b1;
               end else begin
                  wd_ff <= s_rd;
                  b_ff <= b_ff + 1'b1;
               end
            end
         end
         S_OUT_RD: state_ff <= S_OUT_W;
         S_OUT_W: begin
            ha_ff <= d_rd;
            state_ff <= S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (rsp_tlast) begin
                  cnt_ff <= '0;
                  cmp_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= S_LOAD;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  rd_a_ff <= AW'(k_ff + 1'b1);
                  state_ff <= S_OUT_RD;
               end
            end
         end
         default: state_ff <= S_LOAD;
      endcase
      if (reset) begin
         state_ff <= S_LOAD;
         thr_ff <= ThreshReset;
         cnt_ff <= '0;
         cmp_ff <= '0;
         ovf_ff <= 1'b0;
         sp_ff <= '0;
         we_ff <= 1'b0;
         swe_ff <= 1'b0;
      end
   end

   a_no_rsp_while_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("rsp while loading");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= NW'(MAX_ELEMENTS)) else $error("count beyond capacity");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output changed under stall");
endmodule
`default_nettype wire

// File: rtl/hims_ram.sv
`default_nettype none
module hims_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
